/* design/akwq_pkg.sv */
// Shared types and codes for the address-keyed wait queue.
// Holds the item structs, command and status codes and default sizes.
// No dependencies.
package akwq_pkg;

  localparam int DefAddressSlots   = 8;
  localparam int DefWaitersPerSlot = 16;
  localparam int DefIdBits         = 8;

  localparam int CmdW       = 4;
  localparam int AddrW      = 32;
  localparam int WordW      = 32;
  localparam int IdFieldW   = 8;
  localparam int StatusW    = 2;

  localparam logic [CmdW-1:0] OpWait = 4'd0;
  localparam logic [CmdW-1:0] OpWake = 4'd1;

  localparam logic [StatusW-1:0] StDone        = 2'd0;
  localparam logic [StatusW-1:0] StMismatch    = 2'd1;
  localparam logic [StatusW-1:0] StTableFull   = 2'd2;
  localparam logic [StatusW-1:0] StUnsupported = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]         command;
    logic [AddrW-1:0]        word_address;
    logic signed [WordW-1:0] operand_value;
    logic signed [WordW-1:0] current_word;
    logic [IdFieldW-1:0]     waiter_id;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic                went_to_sleep;
    logic                wake_valid;
    logic [IdFieldW-1:0] woken_id;
    logic                last;
  } out_item_t;

endpackage

/* design/address_keyed_wait_queue_unit.sv */
// Address-keyed wait queue: slot table, waiter stacks and the sequencer.
// Depends on akwq_pkg for item types, command and status codes.
//
// Usage: items enter on in_valid_i/in_ready_o carrying a command, a word
// address, an operand, the word's present value and a waiter id. Results
// leave on out_valid_o/out_ready_i; each input gives one result item, or
// one item per released waiter for a wake, the final one flagged by last.
// in_ready_o is high only while the sequencer is idle: one item at a time.
// A wait or wake scans the slot keys one slot per cycle through a single
// comparator on a registered key-memory port. A mismatched wait or an
// unsupported command skips the scan and goes straight to the response;
// a wake releases one waiter per cycle from the waiter memory's single
// read port while the receiver keeps taking them.
// Reset clears the slot-in-use bits and the sequencer; keys, counts and
// waiter ids are written before they are ever read, so need no clearing.
// A stalled receiver holds the output register; the sequencer waits on it
// and the next item can be accepted while the last result is still held.
module address_keyed_wait_queue_unit
  import akwq_pkg::*;
#(
  parameter int ADDRESS_SLOTS    = DefAddressSlots,
  parameter int WAITERS_PER_SLOT = DefWaitersPerSlot,
  parameter int ID_BITS          = DefIdBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int SW    = (ADDRESS_SLOTS > 1) ? $clog2(ADDRESS_SLOTS) : 1;
  localparam int CNT_W = $clog2(WAITERS_PER_SLOT + 1);
  localparam int DEPTH = ADDRESS_SLOTS * WAITERS_PER_SLOT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SW-1:0]    LastSlot = SW'(ADDRESS_SLOTS - 1);
  localparam logic [CNT_W-1:0] CntMax   = CNT_W'(WAITERS_PER_SLOT);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_q, state_d;

  // storage
  logic [AddrW-1:0]   key_mem [ADDRESS_SLOTS];
  logic [CNT_W-1:0]   cnt_mem [ADDRESS_SLOTS];
  logic [ID_BITS-1:0] store   [DEPTH];
  logic [ADDRESS_SLOTS-1:0] in_use_q;

  logic [AddrW-1:0]   key_rd_q;
  logic [CNT_W-1:0]   cnt_rd_q;
  logic [ID_BITS-1:0] st_rd_q;

  in_item_t         req_q;
  logic [SW-1:0]    scan_q, cmp_idx_q, free_q, slot_q;
  logic             free_vld_q;
  logic [AW-1:0]    base_q;
  logic [CNT_W-1:0] pos_q, rem_q;
  logic             up_q;
  logic [StatusW-1:0] resp_status_q;
  logic             resp_slept_q;
  logic             out_valid_q;
  out_item_t        out_q;

  // memory ports
  logic             key_we, cnt_we, st_we, rd_en;
  logic [SW-1:0]    key_ra, cnt_wa;
  logic [CNT_W-1:0] cnt_wd;
  logic [AW-1:0]    st_wa, rd_addr;
  logic [ID_BITS-1:0] id_in;

  logic accept, out_free, load_out;
  logic hit, scan_end, any_free, is_wait, is_wake, neg, release_all;
  logic [SW-1:0] free_slot;
  logic [WordW-1:0] v;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = ((state_q == S_RESP) || (state_q == S_EMIT)) && out_free;

  assign is_wait  = (req_q.command == OpWait);
  assign is_wake  = (req_q.command == OpWake);
  assign hit      = in_use_q[cmp_idx_q] && (key_rd_q == req_q.word_address);
  assign scan_end = (cmp_idx_q == LastSlot);
  assign any_free = free_vld_q || !in_use_q[cmp_idx_q];
  assign free_slot = free_vld_q ? free_q : cmp_idx_q;
  assign v        = $unsigned(req_q.operand_value);
  assign neg      = v[WordW-1];
  assign release_all = !neg && (WordW'(cnt_rd_q) <= v);
  assign id_in    = ID_BITS'(req_q.waiter_id);
  assign key_ra   = (state_q == S_IDLE) ? '0 : scan_q;
  assign rd_addr  = base_q + AW'(pos_q);

  always_comb begin
    state_d = state_q;
    key_we  = 1'b0;
    cnt_we  = 1'b0;
    cnt_wa  = slot_q;
    cnt_wd  = '0;
    st_we   = 1'b0;
    st_wa   = base_q + AW'(cnt_rd_q);
    rd_en   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.command == OpWait) begin
            if (in_data_i.current_word != in_data_i.operand_value) begin
              state_d = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end else if (in_data_i.command == OpWake) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_DECIDE;
        end else if (scan_end) begin
          state_d = S_RESP;
          if (is_wait && any_free) begin
            // allocate the lowest free slot and push the first waiter
            key_we = 1'b1;
            cnt_we = 1'b1;
            cnt_wa = free_slot;
            cnt_wd = CNT_W'(1);
            st_we  = 1'b1;
            st_wa  = AW'(free_slot * WAITERS_PER_SLOT);
          end
        end
      end
      S_DECIDE: begin
        state_d = S_RESP;
        if (is_wait) begin
          if (cnt_rd_q < CntMax) begin
            st_we  = 1'b1;
            cnt_we = 1'b1;
            cnt_wd = cnt_rd_q + CNT_W'(1);
          end
        end else if (release_all) begin
          if (cnt_rd_q != '0) begin
            cnt_we  = 1'b1;
            state_d = S_READ;
          end
        end else if (!neg && (v != '0)) begin
          cnt_we  = 1'b1;
          cnt_wd  = cnt_rd_q - v[CNT_W-1:0];
          state_d = S_READ;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (rem_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_use_q    <= '0;
      out_valid_q <= 1'b0;
      free_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        free_vld_q <= 1'b0;
      end else if (state_q == S_SCAN && !free_vld_q && !in_use_q[cmp_idx_q]) begin
        free_vld_q <= 1'b1;
      end
      if (state_q == S_SCAN && !hit && scan_end && is_wait && any_free) begin
        in_use_q[free_slot] <= 1'b1;
      end
      if (state_q == S_DECIDE && is_wake && release_all) begin
        in_use_q[slot_q] <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= in_data_i;
      cmp_idx_q <= '0;
      scan_q    <= SW'(1);
      if (in_data_i.command == OpWait) begin
        resp_status_q <= StMismatch;
      end else begin
        resp_status_q <= StUnsupported;
      end
      resp_slept_q <= 1'b0;
    end
    unique case (state_q)
      S_SCAN: begin
        if (!free_vld_q && !in_use_q[cmp_idx_q]) begin
          free_q <= cmp_idx_q;
        end
        if (hit) begin
          slot_q <= cmp_idx_q;
          base_q <= AW'(cmp_idx_q * WAITERS_PER_SLOT);
        end else if (scan_end) begin
          if (is_wait && any_free) begin
            resp_status_q <= StDone;
            resp_slept_q  <= 1'b1;
          end else if (is_wait) begin
            resp_status_q <= StTableFull;
          end else begin
            resp_status_q <= StDone;
          end
        end else begin
          // advance the scan by one slot
          cmp_idx_q <= scan_q;
          scan_q    <= scan_q + SW'(1);
        end
      end
      S_DECIDE: begin
        if (is_wait) begin
          resp_status_q <= (cnt_rd_q < CntMax) ? StDone : StTableFull;
          resp_slept_q  <= (cnt_rd_q < CntMax);
        end else begin
          resp_status_q <= StDone;
        end
        if (release_all) begin
          pos_q <= '0;
          rem_q <= cnt_rd_q;
          up_q  <= 1'b1;
        end else begin
          pos_q <= cnt_rd_q - CNT_W'(1);
          rem_q <= v[CNT_W-1:0];
          up_q  <= 1'b0;
        end
      end
      default: ;
    endcase
    if (rd_en) begin
      pos_q <= up_q ? pos_q + CNT_W'(1) : pos_q - CNT_W'(1);
    end
    if (load_out) begin
      if (state_q == S_EMIT) begin
        out_q.status        <= StDone;
        out_q.went_to_sleep <= 1'b0;
        out_q.wake_valid    <= 1'b1;
        out_q.woken_id      <= IdFieldW'(st_rd_q);
        out_q.last          <= (rem_q == CNT_W'(1));
        rem_q               <= rem_q - CNT_W'(1);
      end else begin
        out_q.status        <= resp_status_q;
        out_q.went_to_sleep <= resp_slept_q;
        out_q.wake_valid    <= 1'b0;
        out_q.woken_id      <= '0;
        out_q.last          <= 1'b1;
      end
    end
  end

  // slot key memory
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[free_slot] <= req_q.word_address;
    end
    key_rd_q <= key_mem[key_ra];
  end

  // waiter count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cmp_idx_q];
  end

  // waiter id memory
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store[st_wa] <= id_in;
    end
    if (rd_en) begin
      st_rd_q <= store[rd_addr];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer took a second item without finishing the first");

  a_non_last_is_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.wake_valid)
    else $error("only released waiters may precede the final item");

  a_wake_not_sleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.wake_valid |->
      !out_data_o.went_to_sleep && (out_data_o.status == StDone))
    else $error("wake item carries wait fields");

  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> rem_q != '0)
    else $error("release loop running with nothing left");

endmodule

/* bench/tb_address_keyed_wait_queue_unit.sv */
// Testbench for address_keyed_wait_queue_unit: directed and random wait/wake traffic.
// Keeps its own copy of the slot table and checks every result item in order.
// Depends on akwq_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_address_keyed_wait_queue_unit;
  import akwq_pkg::*;

  localparam int Slots      = DefAddressSlots;
  localparam int Depth      = DefWaitersPerSlot;
  localparam int KeyCount   = 10;
  localparam int HoldAtItem = 80;
  localparam int HoldCycles = 400;
  localparam int CycleLimit = 500000;

  // Tracks the slot table and holds the result items each accepted item is due to give.
  class wait_table_tracker;
    bit                  slot_used [Slots];
    logic [AddrW-1:0]    slot_addr [Slots];
    int unsigned         slot_cnt  [Slots];
    logic [IdFieldW-1:0] sleepers  [Slots][Depth];
    out_item_t           due_results [$];
    int                  errors;

    function new();
      errors = 0;
      foreach (slot_used[s]) begin
        slot_used[s] = 1'b0;
        slot_cnt[s]  = 0;
      end
    endfunction

    function void queue_result(logic [StatusW-1:0] st, logic slept, logic wv,
                               logic [IdFieldW-1:0] id, logic fin);
      out_item_t r;
      r.status        = st;
      r.went_to_sleep = slept;
      r.wake_valid    = wv;
      r.woken_id      = id;
      r.last          = fin;
      due_results = {due_results, r};
    endfunction

    function void note_accepted(in_item_t it);
      int          hit;
      int          free_s;
      int unsigned n;
      logic [WordW-1:0] req;
      hit    = -1;
      free_s = -1;
      req    = it.operand_value;
      for (int s = 0; s < Slots; s++) begin
        if (hit < 0 && slot_used[s] && slot_addr[s] == it.word_address) hit = s;
        if (free_s < 0 && !slot_used[s]) free_s = s;
      end
      case (it.command)
        OpWait: begin
          if (it.current_word != it.operand_value) begin
            queue_result(StMismatch, 1'b0, 1'b0, '0, 1'b1);
          end else if (hit < 0 && free_s < 0) begin
            queue_result(StTableFull, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            if (hit < 0) begin
              hit = free_s;
              slot_used[hit] = 1'b1;
              slot_addr[hit] = it.word_address;
              slot_cnt[hit]  = 0;
            end
            if (slot_cnt[hit] >= Depth) begin
              queue_result(StTableFull, 1'b0, 1'b0, '0, 1'b1);
            end else begin
              sleepers[hit][slot_cnt[hit]] = it.waiter_id;
              slot_cnt[hit]++;
              queue_result(StDone, 1'b1, 1'b0, '0, 1'b1);
            end
          end
        end
        OpWake: begin
          if (hit < 0) begin
            queue_result(StDone, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            n = slot_cnt[hit];
            if (!req[WordW-1] && n <= req) begin
              // count covers every waiter: release oldest first and free the slot
              if (n == 0) queue_result(StDone, 1'b0, 1'b0, '0, 1'b1);
              for (int unsigned i = 0; i < n; i++)
                queue_result(StDone, 1'b0, 1'b1, sleepers[hit][i], i + 1 == n);
              slot_used[hit] = 1'b0;
              slot_cnt[hit]  = 0;
            end else if (req[WordW-1] || req == 0) begin
              queue_result(StDone, 1'b0, 1'b0, '0, 1'b1);
            end else begin
              // partial release pops newest first
              for (int unsigned i = 0; i < req; i++) begin
                n--;
                queue_result(StDone, 1'b0, 1'b1, sleepers[hit][n], i + 1 == req);
              end
              slot_cnt[hit] = n;
            end
          end
        end
        default: queue_result(StUnsupported, 1'b0, 1'b0, '0, 1'b1);
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result item %p", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.went_to_sleep !== want.went_to_sleep) begin
        $error("went_to_sleep: expected %0d, got %0d", want.went_to_sleep, got.went_to_sleep);
        errors++;
      end
      if (got.wake_valid !== want.wake_valid) begin
        $error("wake_valid: expected %0d, got %0d", want.wake_valid, got.wake_valid);
        errors++;
      end
      if (got.woken_id !== want.woken_id) begin
        $error("woken_id: expected %0h, got %0h", want.woken_id, got.woken_id);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  wait_table_tracker tracker;
  logic [AddrW-1:0]  key_pool [KeyCount];
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  int                items_in    = 0;
  int                hold_left   = 0;
  bit                hold_done   = 1'b0;
  int                cycles      = 0;

  address_keyed_wait_queue_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Both handshakes are sampled before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        tracker.note_accepted(in_data);
        items_in <= items_in + 1;
      end
      if (out_valid && out_ready) tracker.check_result(out_data);
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the unit up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in == HoldAtItem) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_item_t compose(logic [CmdW-1:0] cmd, logic [AddrW-1:0] addr,
                                       logic [WordW-1:0] opv, logic [WordW-1:0] cur,
                                       logic [IdFieldW-1:0] id);
    in_item_t it;
    it.command       = cmd;
    it.word_address  = addr;
    it.operand_value = opv;
    it.current_word  = cur;
    it.waiter_id     = id;
    return it;
  endfunction

  // Called just after a rising edge; returns at the edge that accepts the item.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic in_item_t random_item();
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] v;
    logic [WordW-1:0] cur;
    int               pick;
    int               r;
    pick = $urandom_range(99);
    addr = ($urandom_range(99) < 88) ? key_pool[$urandom_range(KeyCount - 1)] : $urandom;
    if (pick < 55) begin
      v   = $urandom;
      cur = v;
      if ($urandom_range(99) >= 85)
        cur = $urandom_range(1) ? $urandom : v ^ (32'd1 << $urandom_range(31));
      return compose(OpWait, addr, v, cur, IdFieldW'($urandom));
    end
    if (pick < 92) begin
      r = $urandom_range(99);
      if (r < 45)      v = $urandom_range(4, 1);
      else if (r < 57) v = '0;
      else if (r < 69) v = $urandom | 32'h8000_0000;
      else if (r < 81) v = $urandom_range(Depth, 5);
      else             v = $urandom & 32'h7fff_ffff;
      return compose(OpWake, addr, v, $urandom, IdFieldW'($urandom));
    end
    return compose(CmdW'($urandom_range(15, 2)), $urandom, $urandom, $urandom,
                   IdFieldW'($urandom));
  endfunction

  task automatic run_phase(int n_items, int tx_pct, int rx_pct);
    int               sent;
    int               burst;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] v;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 20) begin
        // run of matching waits on one key: builds deep stacks and can overflow them
        addr  = key_pool[$urandom_range(KeyCount - 1)];
        burst = $urandom_range(Depth + 2, 3);
        repeat (burst) begin
          v = $urandom;
          send_item(compose(OpWait, addr, v, v, IdFieldW'($urandom)));
        end
        sent += burst;
      end else begin
        send_item(random_item());
        sent++;
      end
    end
  endtask

  initial begin
    tracker     = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < KeyCount; k++) key_pool[k] = $urandom;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(compose(OpWake, '0, 32'd5, '0, '0));
    send_item(compose(OpWait, '0, 32'h8000_0000, 32'h8000_0000, 8'h00));
    send_item(compose(OpWait, '0, 32'h7fff_ffff, 32'h7fff_ffff, 8'hff));
    send_item(compose(OpWait, '0, 32'd0, 32'd1, 8'h11));
    send_item(compose(OpWait, '0, 32'hffff_ffff, 32'h7fff_ffff, 8'h22));
    send_item(compose(OpWait, '1, 32'hffff_ffff, 32'hffff_ffff, 8'ha5));
    send_item(compose(OpWait, '1, 32'h0000_0000, 32'h0000_0000, 8'h5a));
    send_item(compose(OpWait, '1, 32'h1234_5678, 32'h1234_5678, 8'h3c));
    send_item(compose(OpWake, '0, 32'd0, '0, '0));
    send_item(compose(OpWake, '0, 32'hffff_ffff, '0, '0));
    send_item(compose(OpWake, '0, 32'h8000_0000, '0, '0));
    send_item(compose(OpWake, '1, 32'd2, '1, '1));
    send_item(compose(OpWake, '0, 32'd2, '0, '0));
    send_item(compose(OpWake, '1, 32'h7fff_ffff, '0, '0));
    send_item(compose(OpWake, '1, 32'd1, '0, '0));
    send_item(compose(CmdW'(2), '1, '1, '1, '1));
    send_item(compose(CmdW'(4), '0, '0, '0, '0));
    send_item(compose(CmdW'(8), $urandom, $urandom, $urandom, IdFieldW'($urandom)));
    send_item(compose(CmdW'(15), '1, '0, '1, '0));

    run_phase(148, 22, 61);
    run_phase(148, 61, 22);
    run_phase(146, 0, 0);
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (Slots + Depth + 16) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
